// ===== hdl/onh_pkg.sv =====
// ----------------------------------------------------------------------------
// onh_pkg
// Shared constants, the permutation table and small arithmetic helpers for
// the three-octave gradient noise height generator.
// ----------------------------------------------------------------------------
package onh_pkg;

    localparam int COORD_BITS_DEF = 12;

    // Octave frequencies in Q0.16.
    localparam logic [15:0] FREQ_LOW  = 16'd655;
    localparam logic [15:0] FREQ_MID  = 16'd3277;
    localparam logic [15:0] FREQ_HIGH = 16'd32768;

    // Mix weights in Q0.16.
    localparam logic [15:0] MIX_A       = 16'd47186;
    localparam logic [15:0] MIX_AB      = 16'd26214;
    localparam logic [15:0] MIX_AAC     = 16'd6554;
    localparam logic [15:0] WATER_SHIFT = 16'd6554;

    localparam logic [7:0] PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    // Gradient dot product for one corner, selected by the low hash nibble.
    function automatic logic signed [18:0] corner_dot(input logic [3:0] code,
                                                      input logic signed [17:0] dx,
                                                      input logic signed [17:0] dy);
        logic signed [18:0] s1;
        logic signed [18:0] s2;
        logic signed [18:0] ex;
        logic signed [18:0] ey;
        ex = 19'(dx);
        ey = 19'(dy);
        s1 = (code < 4'd8) ? ex : ey;
        if (code < 4'd4) begin
            s2 = ey;
        end else if (code == 4'd12 || code == 4'd14) begin
            s2 = ex;
        end else begin
            s2 = '0;
        end
        corner_dot = (code[0] ? -s1 : s1) + (code[1] ? -s2 : s2);
    endfunction

    // 6t^5 - 15t^4 + 10t^3, clamped to 0..1.0.
    function automatic logic [16:0] fade_sum(input logic [15:0] t3,
                                             input logic [15:0] t4,
                                             input logic [15:0] t5);
        logic signed [22:0] r;
        r = 23'sd6 * $signed({7'b0, t5}) - 23'sd15 * $signed({7'b0, t4})
            + 23'sd10 * $signed({7'b0, t3});
        if (r < 0) begin
            fade_sum = '0;
        end else if (r > 23'sd65536) begin
            fade_sum = 17'd65536;
        end else begin
            fade_sum = r[16:0];
        end
    endfunction

    // lo + floor(w * (hi - lo) / 2^16)
    function automatic logic signed [18:0] lerp(input logic [16:0] w,
                                                input logic signed [18:0] lo,
                                                input logic signed [18:0] hi);
        logic signed [19:0] d;
        logic signed [37:0] p;
        d = 20'(hi) - 20'(lo);
        p = 38'($signed({1'b0, w})) * 38'(d);
        lerp = lo + 19'(p >>> 16);
    endfunction

endpackage

// ===== hdl/onh_octave.sv =====
// ----------------------------------------------------------------------------
// onh_octave
// One noise octave as a nine-stage pipeline: scaling, fade powers, hashing,
// gradients, fade, two lerp levels and the final (1+n)/2 mapping.
// ----------------------------------------------------------------------------
module onh_octave #(
    parameter int          COORD_BITS = onh_pkg::COORD_BITS_DEF,
    parameter logic [15:0] FREQ       = onh_pkg::FREQ_LOW
) (
    input  logic                    i_clk,
    input  logic [COORD_BITS-1:0]   i_x,
    input  logic [COORD_BITS-1:0]   i_y,
    input  logic [7:0]              i_seed,
    output logic signed [18:0]      o_scale
);
    import onh_pkg::*;

    localparam int SW = COORD_BITS + 16;

    // Index 0 is the x axis, index 1 the y axis.
    logic [SW-1:0]          r_s    [2];
    logic [15:0]            r_f2   [2];
    logic [15:0]            r_p2   [2];
    logic [15:0]            r_f3   [2];
    logic [15:0]            r_p3a  [2];
    logic [15:0]            r_f4   [2];
    logic [15:0]            r_p3b  [2];
    logic [15:0]            r_p4   [2];
    logic [15:0]            r_p3c  [2];
    logic [15:0]            r_p4c  [2];
    logic [15:0]            r_p5   [2];
    logic [16:0]            r_w6   [2];
    logic [16:0]            r_wv7;

    logic [7:0]             r_ra, r_rb;
    logic [7:0]             r_qaa, r_qab, r_qba, r_qbb;
    logic [3:0]             r_caa, r_cab, r_cba, r_cbb;
    logic signed [18:0]     r_g00, r_g10, r_g01, r_g11;
    logic signed [18:0]     r_g00b, r_g10b, r_g01b, r_g11b;
    logic signed [18:0]     r_n0, r_n1, r_n;
    logic signed [18:0]     r_scale;

    logic [SW-1:0]          n_s [2];
    logic [7:0]             n_cx, n_cy;
    logic [31:0]            n_sq [2];
    logic [31:0]            n_cu [2];
    logic [31:0]            n_qu [2];
    logic [31:0]            n_qi [2];
    logic signed [17:0]     n_dx0, n_dx1, n_dy0, n_dy1;
    logic signed [19:0]     n_sum;

    assign n_s[0] = SW'(i_x) * SW'(FREQ);
    assign n_s[1] = SW'(i_y) * SW'(FREQ);
    assign n_cx   = r_s[0][23:16];
    assign n_cy   = r_s[1][23:16];
    assign n_dx0  = $signed({2'b0, r_f4[0]});
    assign n_dy0  = $signed({2'b0, r_f4[1]});
    assign n_dx1  = n_dx0 - 18'sd65536;
    assign n_dy1  = n_dy0 - 18'sd65536;
    assign n_sum  = 20'sd65536 + 20'(r_n);

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_sq[k] = 32'(r_s[k][15:0]) * 32'(r_s[k][15:0]);
            n_cu[k] = 32'(r_p2[k]) * 32'(r_f2[k]);
            n_qu[k] = 32'(r_p3a[k]) * 32'(r_f3[k]);
            n_qi[k] = 32'(r_p4[k]) * 32'(r_f4[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_s[k]   <= n_s[k];
            r_f2[k]  <= r_s[k][15:0];
            r_p2[k]  <= n_sq[k][31:16];
            r_f3[k]  <= r_f2[k];
            r_p3a[k] <= n_cu[k][31:16];
            r_f4[k]  <= r_f3[k];
            r_p3b[k] <= r_p3a[k];
            r_p4[k]  <= n_qu[k][31:16];
            r_p3c[k] <= r_p3b[k];
            r_p4c[k] <= r_p4[k];
            r_p5[k]  <= n_qi[k][31:16];
            r_w6[k]  <= fade_sum(r_p3c[k], r_p4c[k], r_p5[k]);
        end
        // Hash chain: x cell, then y cell, then the seed slice on the z floor.
        r_ra   <= PERM[n_cx] + n_cy;
        r_rb   <= PERM[n_cx + 8'd1] + n_cy;
        r_qaa  <= PERM[r_ra] + i_seed;
        r_qab  <= PERM[r_ra + 8'd1] + i_seed;
        r_qba  <= PERM[r_rb] + i_seed;
        r_qbb  <= PERM[r_rb + 8'd1] + i_seed;
        r_caa  <= PERM[r_qaa][3:0];
        r_cab  <= PERM[r_qab][3:0];
        r_cba  <= PERM[r_qba][3:0];
        r_cbb  <= PERM[r_qbb][3:0];
        r_g00  <= corner_dot(r_caa, n_dx0, n_dy0);
        r_g10  <= corner_dot(r_cba, n_dx1, n_dy0);
        r_g01  <= corner_dot(r_cab, n_dx0, n_dy1);
        r_g11  <= corner_dot(r_cbb, n_dx1, n_dy1);
        r_g00b <= r_g00;
        r_g10b <= r_g10;
        r_g01b <= r_g01;
        r_g11b <= r_g11;
        r_n0   <= lerp(r_w6[0], r_g00b, r_g10b);
        r_n1   <= lerp(r_w6[0], r_g01b, r_g11b);
        r_wv7  <= r_w6[1];
        r_n    <= lerp(r_wv7, r_n0, r_n1);
        r_scale <= 19'(n_sum >>> 1);
    end

    assign o_scale = r_scale;

endmodule

// ===== hdl/octave_noise_height_generator.sv =====
// ----------------------------------------------------------------------------
// octave_noise_height_generator
// Terrain height from three octaves of gradient noise, mixed and clamped to
// a byte. Fully pipelined, one sample per clock.
// ----------------------------------------------------------------------------
// The height strobes once start is taken and the sample has passed the 9 octave
// stages and 4 mix stages. Throughput: one sample every cycle; busy stays low.
// The receiver cannot stall, so nothing in the pipeline ever holds.
// Reset (synchronous, active low) clears the valid pipeline and sets the
// seed slice to 0. The permutation table is constant logic.
module octave_noise_height_generator #(
    parameter int COORD_BITS = onh_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_x_coord,
    input  logic [COORD_BITS-1:0] i_y_coord,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_data,
    output logic                  o_valid,
    output logic [7:0]            o_height
);
    import onh_pkg::*;

    localparam int PIPE_DEPTH = 13;

    logic [PIPE_DEPTH-1:0]  r_vld;
    logic [7:0]             r_seed;
    logic signed [18:0]     n_a, n_b, n_c;

    logic signed [19:0]     r_t1a, r_t1b;
    logic signed [21:0]     r_ab, r_aa;
    logic signed [18:0]     r_c1;
    logic signed [22:0]     r_t2;
    logic signed [24:0]     r_aac;
    logic signed [27:0]     r_v;
    logic [7:0]             r_height;

    logic signed [35:0]     n_pa;
    logic signed [37:0]     n_pab, n_paa;
    logic signed [38:0]     n_pt2;
    logic signed [40:0]     n_paac;
    logic signed [41:0]     n_pt3;
    logic signed [27:0]     n_v;
    logic [35:0]            n_vs;

    onh_octave #(.COORD_BITS(COORD_BITS), .FREQ(FREQ_LOW)) u_oct_low (
        .i_clk(i_clk), .i_x(i_x_coord), .i_y(i_y_coord), .i_seed(r_seed), .o_scale(n_a)
    );
    onh_octave #(.COORD_BITS(COORD_BITS), .FREQ(FREQ_MID)) u_oct_mid (
        .i_clk(i_clk), .i_x(i_x_coord), .i_y(i_y_coord), .i_seed(r_seed), .o_scale(n_b)
    );
    onh_octave #(.COORD_BITS(COORD_BITS), .FREQ(FREQ_HIGH)) u_oct_high (
        .i_clk(i_clk), .i_x(i_x_coord), .i_y(i_y_coord), .i_seed(r_seed), .o_scale(n_c)
    );

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_seed <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], start & ~busy};
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_pa   = 36'($signed({1'b0, MIX_A})) * 36'(n_a);
        n_pab  = 38'(n_a) * 38'(n_b);
        n_paa  = 38'(n_a) * 38'(n_a);
        n_pt2  = 39'($signed({1'b0, MIX_AB})) * 39'(r_ab);
        n_paac = 41'(r_aa) * 41'(r_c1);
        n_pt3  = 42'($signed({1'b0, MIX_AAC})) * 42'(r_aac);
        n_v    = 28'(r_t1b) + 28'(r_t2) + 28'(n_pt3 >>> 16)
                 - 28'($signed({1'b0, WATER_SHIFT}));
        n_vs   = 36'(r_v) * 36'd255;
    end

    always_ff @(posedge i_clk) begin
        // Mix stage 1: a weighted, a*b and a*a.
        r_t1a <= 20'(n_pa >>> 16);
        r_ab  <= 22'(n_pab >>> 16);
        r_aa  <= 22'(n_paa >>> 16);
        r_c1  <= n_c;
        // Mix stage 2.
        r_t1b <= r_t1a;
        r_t2  <= 23'(n_pt2 >>> 16);
        r_aac <= 25'(n_paac >>> 16);
        // Mix stage 3.
        r_v   <= n_v;
        // Scale to a byte; anything at or below the water line is zero.
        if (r_v <= 0) begin
            r_height <= '0;
        end else if (n_vs[35:16] > 20'd255) begin
            r_height <= 8'd255;
        end else begin
            r_height <= n_vs[23:16];
        end
    end

    // The mix stages above hold r_t1a and r_t1b so that the weighted a term
    // lines up with the product terms of the same sample.
    assign o_valid  = r_vld[PIPE_DEPTH-1];
    assign o_height = r_height;

    a_start_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_DEPTH o_valid)
        else $error("accepted sample did not produce a height strobe");

    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, PIPE_DEPTH))
        else $error("height strobe without an accepted sample");

    a_seed_only_on_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cfg_valid) |-> $stable(r_seed))
        else $error("seed slice changed without a configuration transfer");

endmodule

// ===== tb/tb_octave_noise_height_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_octave_noise_height_generator
// Drives coordinate samples into the noise height generator under several
// idling patterns and seed slices, predicts each height in fixed point, and
// compares every strobed height in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb_octave_noise_height_generator;
    import onh_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [CB-1:0] i_x_coord;
    logic [CB-1:0] i_y_coord;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [7:0]    i_cfg_data;
    logic          o_valid;
    logic [7:0]    o_height;

    logic [7:0] seed_shadow;
    logic [7:0] height_queue[$];
    int         error_count;
    int         idle_count;
    int         sent_count;
    int         checked_count;
    int         send_idle_pct;

    octave_noise_height_generator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_x_coord(i_x_coord), .i_y_coord(i_y_coord),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_height(o_height)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic longint fl16(input longint v);
        return v >>> 16;
    endfunction

    function automatic longint fade_q16(input longint t);
        longint t2, t3, t4, t5, r;
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        t4 = (t3 * t) >> 16;
        t5 = (t4 * t) >> 16;
        r = 6 * t5 - 15 * t4 + 10 * t3;
        if (r < 0) r = 0;
        if (r > 65536) r = 65536;
        return r;
    endfunction

    function automatic longint grad_dot(input int code, input longint dx, input longint dy);
        int h;
        longint s1, s2;
        h = code & 15;
        s1 = (h < 8) ? dx : dy;
        s2 = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : 0);
        return ((h & 1) ? -s1 : s1) + ((h & 2) ? -s2 : s2);
    endfunction

    function automatic int hash_at(input int i);
        return int'(PERM[i & 255]);
    endfunction

    // Returns (1 + n) / 2 in Q2.16 for one frequency.
    function automatic longint octave_level(input longint xc, input longint yc,
                                            input longint freq, input int cz);
        longint sx, sy, fx, fy, wu, wv, g00, g10, g01, g11, lo, hi, n;
        int cx, cy, ra, rb;
        sx = xc * freq;
        sy = yc * freq;
        cx = int'((sx >> 16) & 255);
        cy = int'((sy >> 16) & 255);
        fx = sx & 16'hFFFF;
        fy = sy & 16'hFFFF;
        wu = fade_q16(fx);
        wv = fade_q16(fy);
        ra = hash_at(cx) + cy;
        rb = hash_at(cx + 1) + cy;
        g00 = grad_dot(hash_at(hash_at(ra) + cz), fx, fy);
        g01 = grad_dot(hash_at(hash_at(ra + 1) + cz), fx, fy - 65536);
        g10 = grad_dot(hash_at(hash_at(rb) + cz), fx - 65536, fy);
        g11 = grad_dot(hash_at(hash_at(rb + 1) + cz), fx - 65536, fy - 65536);
        lo = g00 + fl16(wu * (g10 - g00));
        hi = g01 + fl16(wu * (g11 - g01));
        n = lo + fl16(wv * (hi - lo));
        return (65536 + n) >>> 1;
    endfunction

    function automatic logic [7:0] terrain_height(input logic [CB-1:0] xc,
                                                  input logic [CB-1:0] yc,
                                                  input logic [7:0] seed);
        longint a, b, c, v, h;
        a = octave_level(xc, yc, FREQ_LOW, seed);
        b = octave_level(xc, yc, FREQ_MID, seed);
        c = octave_level(xc, yc, FREQ_HIGH, seed);
        v = fl16(MIX_A * a) + fl16(MIX_AB * fl16(a * b))
            + fl16(MIX_AAC * fl16(fl16(a * a) * c)) - WATER_SHIFT;
        if (v <= 0) h = 0;
        else begin
            h = (v * 255) >> 16;
            if (h > 255) h = 255;
        end
        return h[7:0];
    endfunction

    // Result checker and stall watchdog.
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && o_valid) begin
            if (height_queue.size() == 0) begin
                $error("height: unexpected result %0d", o_height);
                error_count++;
            end else begin
                want = height_queue.pop_front();
                checked_count++;
                if (o_height !== want) begin
                    $error("height: expected %0d, actual %0d", want, o_height);
                    error_count++;
                end
            end
        end
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("tb_octave_noise_height_generator: done, errors");
            $finish;
        end
    end

    // Start stays high across back-to-back samples; idle gaps and the drain
    // task drop it.
    task automatic send_sample(input logic [CB-1:0] xc, input logic [CB-1:0] yc);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_x_coord <= xc;
        i_y_coord <= yc;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        height_queue.push_back(terrain_height(xc, yc, seed_shadow));
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (height_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [7:0] seed);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= seed;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        seed_shadow = seed;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_corners();
        logic [CB-1:0] edges[4] = '{CB'(0), CB'(1), CB'(4095), CB'(2048)};
        send_idle_pct = 0;
        foreach (edges[i]) foreach (edges[j]) send_sample(edges[i], edges[j]);
        // Cell wrap at an x of 512 (scaled cell 256) at the highest frequency, and half-cell points.
        send_sample(CB'(511), CB'(0));
        send_sample(CB'(512), CB'(513));
        send_sample(CB'(12'hAAA), CB'(12'h555));
        send_sample(CB'(12'h555), CB'(12'hAAA));
        wait_drained();
    endtask

    task automatic test_seed_extremes();
        write_seed(8'd255);
        send_sample(CB'(0), CB'(0));
        send_sample(CB'(4095), CB'(4095));
        send_sample(CB'(100), CB'(3000));
        write_seed(8'd0);
        send_sample(CB'(100), CB'(3000));
        wait_drained();
    endtask

    task automatic test_random_phase(input int pct, input int count, input logic [7:0] seed);
        write_seed(seed);
        send_idle_pct = pct;
        repeat (count) begin
            if ($urandom_range(3) == 0)
                send_sample(CB'($urandom_range(4095)), CB'($urandom_range(4095)));
            else
                send_sample(CB'($urandom_range(300)), CB'($urandom_range(300)));
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        seed_shadow = 8'd0;
        error_count = 0;
        idle_count = 0;
        sent_count = 0;
        checked_count = 0;
        send_idle_pct = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_corners();
        test_seed_extremes();
        test_random_phase(0, 450, 8'($urandom_range(255)));
        test_random_phase(68, 400, 8'd1);
        test_random_phase(26, 400, 8'($urandom_range(255)));
        test_random_phase(0, 430, 8'd128);
        $display("Covered %0d samples, %0d heights checked, seeds from 0 to 255,",
                 sent_count, checked_count);
        $display("with back-to-back and idle-heavy issue patterns.");
        if (error_count == 0)
            $display("tb_octave_noise_height_generator: done, clean");
        else
            $display("tb_octave_noise_height_generator: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/onh_pkg.sv
hdl/onh_octave.sv
hdl/octave_noise_height_generator.sv
tb/tb_octave_noise_height_generator.sv
